// ----- sv/i2c_bitbang_master_top_defines.svh -----
// Assertion macros used by the checker file of the I2C bit-level master.
`ifndef I2C_BITBANG_MASTER_TOP_DEFINES_SVH
`define I2C_BITBANG_MASTER_TOP_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define I2CBB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked at every rising clock edge, reset included.
`define I2CBB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/i2cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C bit-level master package
// Command codes, word layouts and fixed sequence lengths.
// ----------------------------------------------------------------------------
package i2cbb_pkg;

   typedef enum logic [3:0] {
      CMD_NONE  = 4'd0,
      CMD_START = 4'd1,
      CMD_STOP  = 4'd2,
      CMD_SEND  = 4'd3,
      CMD_READ  = 4'd4,
      CMD_ACKS  = 4'd5,
      CMD_DACK  = 4'd6,
      CMD_DNACK = 4'd7,
      CMD_PROBE = 4'd8
   } cmd_type;

   typedef struct packed {
      logic sda;
      logic scl;
   } line_type;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned TICK_W     = 16;
   localparam int unsigned STEP_W     = 6;

   localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd144;

   localparam logic [STEP_W-1:0] STEPS_BYTE  = 6'd16;
   localparam logic [STEP_W-1:0] STEPS_DACK  = 6'd4;
   localparam logic [STEP_W-1:0] STEPS_PROBE = 6'd25;
   localparam logic [STEP_W-1:0] STEPS_SHORT = 6'd3;

   localparam logic [STEP_W-1:0] PROBE_SEND_AT = 6'd3;
   localparam logic [STEP_W-1:0] PROBE_ACKS_AT = 6'd19;
   localparam logic [STEP_W-1:0] PROBE_STOP_AT = 6'd22;

   localparam logic [3:0] LAST_BIT = 4'd7;

   // Result word bit positions.
   localparam int unsigned RSP_SCL   = 0;
   localparam int unsigned RSP_SDA   = 1;
   localparam int unsigned RSP_BUSY  = 2;
   localparam int unsigned RSP_DONE  = 3;
   localparam int unsigned RSP_READ  = 4;
   localparam int unsigned RSP_NOACK = 12;
   localparam int unsigned RSP_FAULT = 13;
   localparam int unsigned RSP_REJ   = 14;

endpackage

// ----- sv/i2c_bitbang_master_top.sv -----
// ----------------------------------------------------------------------------
// I2C bit-level master
// Open-drain SCL/SDA sequencer stepped by one input word per bus clock tick.
// ----------------------------------------------------------------------------
// Each input word is one tick of the bus sequencer and returns exactly one
// result word. A word is taken every cycle while the result side keeps up;
// the result is computed from the input register and the sequencer state and
// is registered into a two-entry output buffer, which absorbs one result word
// of backpressure without stalling the input.
module i2c_bitbang_master_top
   import i2cbb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [TICK_W-1:0]     csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Bits: data_byte[7:0], sda_level[8], scl_level[9], zero[15:10].
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Bits: req_type[3:0].
   input  logic [3:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Bits: scl_release[0], sda_release[1], busy_res[2], done_res[3],
   // read_value[11:4], no_ack[12], bus_fault[13], cmd_rejected[14], zero[15].
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [TICK_W-1:0]     phase_ticks_ff;
   logic                  in_valid_ff;
   logic [3:0]            in_type_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_sda_ff;
   logic                  in_scl_ff;

   cmd_type               active_ff, active_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [TICK_W-1:0]     tick_ff, tick_in;
   logic [7:0]            shift_ff, shift_in;
   logic [3:0]            bit_ff, bit_in;
   line_type              line_ff, line_in;
   logic                  ack_ff, ack_in;
   logic                  fault_ff, fault_in;
   logic [7:0]            hold_ff, hold_in;
   logic                  done_w, rej_w;

   logic                  main_valid_ff, skid_valid_ff;
   logic [RSP_DATA_W-1:0] main_data_ff, skid_data_ff, result_w;
   logic                  fire, take;

   function automatic logic [STEP_W-1:0] step_count(cmd_type cmd);
      unique case (cmd)
         CMD_SEND, CMD_READ: return STEPS_BYTE;
         CMD_DACK:           return STEPS_DACK;
         CMD_PROBE:          return STEPS_PROBE;
         default:            return STEPS_SHORT;
      endcase
   endfunction

   function automatic cmd_type sub_cmd(cmd_type cmd, logic [STEP_W-1:0] step);
      priority if (cmd != CMD_PROBE) return cmd;
      else if (step < PROBE_SEND_AT) return CMD_START;
      else if (step < PROBE_ACKS_AT) return CMD_SEND;
      else if (step < PROBE_STOP_AT) return CMD_ACKS;
      else return CMD_STOP;
   endfunction

   function automatic logic [STEP_W-1:0] sub_step(cmd_type cmd, logic [STEP_W-1:0] step);
      priority if (cmd != CMD_PROBE) return step;
      else if (step < PROBE_SEND_AT) return step;
      else if (step < PROBE_ACKS_AT) return step - PROBE_SEND_AT;
      else if (step < PROBE_STOP_AT) return step - PROBE_ACKS_AT;
      else return step - PROBE_STOP_AT;
   endfunction

   function automatic line_type phase_enter(cmd_type cmd, logic [STEP_W-1:0] step,
                                            logic msb, line_type cur);
      cmd_type           sc;
      logic [STEP_W-1:0] ss;
      line_type          nl;
      sc = sub_cmd(cmd, step);
      ss = sub_step(cmd, step);
      nl = cur;
      unique case (sc)
         CMD_START: begin
            if (ss == 6'd0) begin
               nl.sda = 1'b1;
               nl.scl = 1'b1;
            end else if (ss == 6'd1) nl.sda = 1'b0;
            else nl.scl = 1'b0;
         end
         CMD_STOP: begin
            if (ss == 6'd0) nl.sda = 1'b0;
            else if (ss == 6'd1) nl.scl = 1'b1;
            else nl.sda = 1'b1;
         end
         CMD_SEND: begin
            if (!ss[0]) nl.sda = msb;
            else nl.scl = 1'b1;
         end
         CMD_READ: nl.scl = ~ss[0];
         CMD_DACK: begin
            if (ss == 6'd0) nl.sda = 1'b0;
            else if (ss == 6'd1) nl.scl = 1'b1;
            else if (ss == 6'd2) nl.scl = 1'b0;
            else nl.sda = 1'b1;
         end
         default: begin
            if (ss == 6'd0) nl.sda = 1'b1;
            else if (ss == 6'd1) nl.scl = 1'b1;
            else nl.scl = 1'b0;
         end
      endcase
      return nl;
   endfunction

   assign fire       = in_valid_ff && !skid_valid_ff;
   assign req_tready = !in_valid_ff || fire;
   assign take       = main_valid_ff && rsp_tready;
   assign rsp_tvalid = main_valid_ff;
   assign rsp_tdata  = main_data_ff;

   always_comb begin
      logic [TICK_W:0]       limit;
      logic [TICK_W:0]       cnt;
      cmd_type               sc;
      logic [STEP_W-1:0]     ss;
      logic [STEP_W-1:0]     nstep;
      active_in = active_ff;
      step_in   = step_ff;
      tick_in   = tick_ff;
      shift_in  = shift_ff;
      bit_in    = bit_ff;
      line_in   = line_ff;
      ack_in    = ack_ff;
      fault_in  = fault_ff;
      hold_in   = hold_ff;
      done_w    = 1'b0;
      rej_w     = 1'b0;
      limit = (phase_ticks_ff == '0) ? 17'd1 : {1'b0, phase_ticks_ff};
      cnt   = {1'b0, tick_ff} + 17'd1;
      sc    = sub_cmd(active_ff, step_ff);
      ss    = sub_step(active_ff, step_ff);
      nstep = step_ff + 6'd1;
      if (active_ff != CMD_NONE) begin
         rej_w = (in_type_ff != CMD_NONE);
         if (cnt >= limit) begin
            if (sc == CMD_SEND && ss[0]) begin
               line_in.scl = 1'b0;
               if (bit_ff == LAST_BIT) line_in.sda = 1'b1;
               shift_in = {shift_ff[6:0], 1'b0};
               bit_in   = bit_ff + 4'd1;
            end else if (sc == CMD_READ && !ss[0]) begin
               shift_in = {shift_ff[6:0], in_sda_ff};
               bit_in   = bit_ff + 4'd1;
            end else if (sc == CMD_ACKS && ss == 6'd1) begin
               ack_in = in_sda_ff;
            end
            tick_in = '0;
            if (nstep >= step_count(active_ff)) begin
               if (active_ff == CMD_READ) hold_in = shift_in;
               active_in = CMD_NONE;
               step_in   = '0;
               done_w    = 1'b1;
            end else begin
               step_in = nstep;
               line_in = phase_enter(active_ff, nstep, shift_in[7], line_in);
            end
         end else begin
            tick_in = cnt[TICK_W-1:0];
         end
      end else if (in_type_ff >= CMD_START && in_type_ff <= CMD_PROBE) begin
         if (in_type_ff == CMD_PROBE && !(in_sda_ff && in_scl_ff)) begin
            fault_in = 1'b1;
            ack_in   = 1'b1;
            done_w   = 1'b1;
         end else begin
            if (in_type_ff == CMD_PROBE) fault_in = 1'b0;
            active_in = cmd_type'(in_type_ff);
            step_in   = '0;
            tick_in   = '0;
            shift_in  = (in_type_ff == CMD_READ) ? 8'h00 : in_byte_ff;
            bit_in    = '0;
            line_in   = phase_enter(cmd_type'(in_type_ff), 6'd0, shift_in[7], line_ff);
         end
      end
      result_w                           = '0;
      result_w[RSP_SCL]                  = line_in.scl;
      result_w[RSP_SDA]                  = line_in.sda;
      result_w[RSP_BUSY]                 = (active_in != CMD_NONE);
      result_w[RSP_DONE]                 = done_w;
      result_w[RSP_READ +: 8]            = hold_in;
      result_w[RSP_NOACK]                = ack_in;
      result_w[RSP_FAULT]                = fault_in;
      result_w[RSP_REJ]                  = rej_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= PHASE_TICKS_RESET;
      end else if (csr_wr_en) begin
         phase_ticks_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
         in_sda_ff  <= req_tdata[8];
         in_scl_ff  <= req_tdata[9];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CMD_NONE;
         step_ff   <= '0;
         tick_ff   <= '0;
         shift_ff  <= '0;
         bit_ff    <= '0;
         line_ff   <= '{sda: 1'b1, scl: 1'b1};
         ack_ff    <= 1'b0;
         fault_ff  <= 1'b0;
         hold_ff   <= '0;
      end else if (fire) begin
         active_ff <= active_in;
         step_ff   <= step_in;
         tick_ff   <= tick_in;
         shift_ff  <= shift_in;
         bit_ff    <= bit_in;
         line_ff   <= line_in;
         ack_ff    <= ack_in;
         fault_ff  <= fault_in;
         hold_ff   <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (take || !main_valid_ff) begin
            main_valid_ff <= skid_valid_ff || fire;
            skid_valid_ff <= 1'b0;
         end else if (fire) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take || !main_valid_ff) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : result_w;
      end
      if (fire && main_valid_ff && !take) begin
         skid_data_ff <= result_w;
      end
   end

endmodule

// ----- sv/i2cbb_checker.sv -----
// ----------------------------------------------------------------------------
// I2C bit-level master port checker
// Watches the result port of the top level: stall hold, reset and flag consistency.
// ----------------------------------------------------------------------------
`include "i2c_bitbang_master_top_defines.svh"

module i2cbb_checker
   import i2cbb_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `I2CBB_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   `I2CBB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result word present right after reset")
   `I2CBB_ASSERT(a_done_idle, rsp_tvalid && rsp_tdata[RSP_DONE] |-> !rsp_tdata[RSP_BUSY], "command finished but still busy")
   `I2CBB_ASSERT(a_rej_busy, rsp_tvalid && rsp_tdata[RSP_REJ] |-> rsp_tdata[RSP_BUSY] || rsp_tdata[RSP_DONE], "rejection reported on an idle tick")

endmodule

bind i2c_bitbang_master_top i2cbb_checker u_i2cbb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
